@@ rtl/core/rht_pkg.sv @@
// rht_pkg: shared types and constants for the rider hazard tracker
// beat payload structs, table entry layout, settings and state codes
// no dependencies
`default_nettype none

package rht_pkg;

   localparam int RIDER_SLOTS = 64;
   localparam int SLOT_BITS   = $clog2(RIDER_SLOTS);
   localparam int POS_BITS    = 16;
   localparam int TIME_BITS   = 32;
   localparam int CNT_BITS    = 16;
   localparam int MS_BITS     = 16;
   localparam int TOL_BITS    = 15;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [POS_BITS-1:0] POS_HALF = {1'b1, {(POS_BITS-1){1'b0}}};
   localparam logic [CNT_BITS-1:0] CNT_MAX  = {CNT_BITS{1'b1}};

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WRONG_WAY_MS   = 3'd0,
      CSR_STATIONARY_MS  = 3'd1,
      CSR_COOLDOWN_MS    = 3'd2,
      CSR_STILL_TOL      = 3'd3,
      CSR_JUMP_THRESHOLD = 3'd4
   } csr_index_type;

   localparam logic [MS_BITS-1:0]  WRONG_WAY_MS_RST   = 16'd1000;
   localparam logic [MS_BITS-1:0]  STATIONARY_MS_RST  = 16'd2000;
   localparam logic [MS_BITS-1:0]  COOLDOWN_MS_RST    = 16'd3000;
   localparam logic [TOL_BITS-1:0] STILL_TOL_RST      = 15'd197;
   localparam logic [TOL_BITS-1:0] JUMP_THRESHOLD_RST = 15'd6554;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_STILL = 2'd1,
      KIND_WRONG = 2'd2
   } hazard_kind_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_CALC = 1'b1
   } state_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] rider_slot;
      logic [POS_BITS-1:0]  lap_fraction;
      logic                 is_crashed;
      logic                 is_excluded;
      logic [TIME_BITS-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] slot_echo;
      logic [1:0]           hazard_kind;
      logic                 hazard_held;
      logic                 going_wrong_way;
      logic [CNT_BITS-1:0]  crash_total;
      logic                 crash_edge;
      logic                 jump_seen;
      logic                 first_seen;
   } rsp_type;

   typedef struct packed {
      logic [MS_BITS-1:0]  wrong_way_ms;
      logic [MS_BITS-1:0]  stationary_ms;
      logic [MS_BITS-1:0]  cooldown_ms;
      logic [TOL_BITS-1:0] still_tolerance;
      logic [TOL_BITS-1:0] jump_threshold;
   } cfg_type;

   typedef struct packed {
      logic [POS_BITS-1:0]  last_pos;
      logic [POS_BITS-1:0]  anchor_pos;
      logic                 prev_crash;
      logic                 back_on;
      logic [TIME_BITS-1:0] back_start;
      logic                 still_on;
      logic [TIME_BITS-1:0] still_start;
      logic                 cool_on;
      logic [TIME_BITS-1:0] cool_start;
      hazard_kind_type      kind;
      logic                 confirmed;
      logic [CNT_BITS-1:0]  crash_cnt;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/core/rht_update.sv @@
// rht_update: next value of one rider entry and the response beat for a sample
// teleport check, wrong-way and dwell timers, hazard machine, crash counter
// depends on rht_pkg
`default_nettype none

module rht_update
   import rht_pkg::*;
(
   input  wire req_type   req,
   input  wire logic      entry_vld,
   input  wire entry_type entry,
   input  wire cfg_type   cfg,
   output entry_type      entry_new,
   output rsp_type        rsp
);

   logic [POS_BITS-1:0]  delta;
   logic [POS_BITS-1:0]  mag;
   logic [POS_BITS-1:0]  adelta;
   logic [POS_BITS-1:0]  amag;
   logic                 backward;
   logic                 jump;
   logic                 moved;
   logic                 ww;
   logic                 still;
   logic                 cond;
   logic                 edge_hit;
   logic [TIME_BITS-1:0] back_start_n;
   logic [TIME_BITS-1:0] still_start_n;
   logic                 still_on_n;
   entry_type            seed;

   always_comb begin
      delta    = req.lap_fraction - entry.last_pos;
      backward = delta > POS_HALF;
      mag      = backward ? (~delta + 1'b1) : delta;
      jump     = mag > {1'b0, cfg.jump_threshold};

      adelta = req.lap_fraction - entry.anchor_pos;
      amag   = (adelta > POS_HALF) ? (~adelta + 1'b1) : adelta;
      moved  = amag > {1'b0, cfg.still_tolerance};

      back_start_n = (backward && !entry.back_on) ? req.now_ms : entry.back_start;
      ww = backward &&
           ((req.now_ms - back_start_n) >= {{(TIME_BITS-MS_BITS){1'b0}}, cfg.wrong_way_ms});

      still_on_n    = !moved;
      still_start_n = (!moved && !entry.still_on) ? req.now_ms : entry.still_start;
      still = still_on_n &&
              ((req.now_ms - still_start_n) >= {{(TIME_BITS-MS_BITS){1'b0}}, cfg.stationary_ms});

      cond     = req.is_crashed || ww || still;
      edge_hit = req.is_crashed && !entry.prev_crash;

      seed             = entry;
      seed.last_pos    = req.lap_fraction;
      seed.anchor_pos  = req.lap_fraction;
      seed.prev_crash  = req.is_crashed;
      seed.back_on     = 1'b0;
      seed.back_start  = '0;
      seed.still_on    = 1'b0;
      seed.still_start = '0;
      seed.cool_on     = 1'b0;
      seed.cool_start  = '0;
      seed.kind        = KIND_NONE;
      seed.confirmed   = 1'b0;

      rsp                 = '0;
      rsp.slot_echo       = req.rider_slot;

      if (!entry_vld) begin
         entry_new           = seed;
         entry_new.crash_cnt = '0;
         rsp.first_seen      = 1'b1;
      end else if (jump) begin
         entry_new     = seed;
         rsp.jump_seen = 1'b1;
      end else begin
         entry_new             = entry;
         entry_new.back_on     = backward;
         entry_new.back_start  = back_start_n;
         entry_new.anchor_pos  = moved ? req.lap_fraction : entry.anchor_pos;
         entry_new.still_on    = still_on_n;
         entry_new.still_start = still_start_n;

         if (req.is_excluded) begin
            entry_new.kind      = KIND_NONE;
            entry_new.confirmed = 1'b0;
            entry_new.cool_on   = 1'b0;
         end else if (cond) begin
            // an unconfirmed crash always opens as stationary
            if (!entry.confirmed && req.is_crashed) begin
               entry_new.kind = KIND_STILL;
            end else begin
               entry_new.kind = ww ? KIND_WRONG : KIND_STILL;
            end
            entry_new.confirmed = 1'b1;
            entry_new.cool_on   = 1'b0;
         end else if (entry.confirmed) begin
            if (!still_on_n && !entry.cool_on) begin
               entry_new.cool_on    = 1'b1;
               entry_new.cool_start = req.now_ms;
            end else if (entry.cool_on &&
                         ((req.now_ms - entry.cool_start) >=
                          {{(TIME_BITS-MS_BITS){1'b0}}, cfg.cooldown_ms})) begin
               entry_new.kind      = KIND_NONE;
               entry_new.confirmed = 1'b0;
               entry_new.cool_on   = 1'b0;
            end
         end

         if (edge_hit && (entry.crash_cnt != CNT_MAX)) begin
            entry_new.crash_cnt = entry.crash_cnt + 1'b1;
         end
         entry_new.prev_crash = req.is_crashed;
         entry_new.last_pos   = req.lap_fraction;

         rsp.going_wrong_way = ww;
         rsp.crash_edge      = edge_hit;
      end

      rsp.hazard_kind = entry_new.kind;
      rsp.hazard_held = entry_new.confirmed;
      rsp.crash_total = entry_new.crash_cnt;
   end

endmodule

`default_nettype wire

@@ rtl/core/rider_hazard_tracker_core.sv @@
// rider_hazard_tracker_core: per-rider motion and hazard monitor over a rider table
// holds the entry memory, valid bits, settings and handshake control
// depends on rht_pkg and rht_update
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+-------------------------
//   req_      | in        | req_valid/req_ready  | req_data (req_type)
//   rsp_      | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
//   csr_      | in        | csr_we, no wait      | csr_index, csr_wdata
//
// each sample passes through a synchronous table read, then an update that writes back
// and loads the response register; one sample is in flight.
// reset clears the valid bits and restores settings; the table needs no clearing.
// a sample waits in the update cycle while the response register is still full.
`default_nettype none

module rider_hazard_tracker_core
   import rht_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   entry_type              mem [RIDER_SLOTS];
   entry_type              rd_data_ff;
   logic [RIDER_SLOTS-1:0] vld_ff;
   req_type                req_ff;
   cfg_type                cfg_ff;
   rsp_type                rsp_data_ff;
   logic                   rsp_valid_ff;
   state_type              state_ff;
   state_type              state_in;

   entry_type              entry_new;
   rsp_type                rsp_new;
   logic                   accept;
   logic                   out_free;
   logic                   mem_we;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      mem_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (out_free) begin
               mem_we   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // table memory: read on accept, write back at the end of the update cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[req_data.rider_slot];
      end
      if (mem_we) begin
         mem[req_ff.rider_slot] <= entry_new;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[req_ff.rider_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrong_way_ms    <= WRONG_WAY_MS_RST;
         cfg_ff.stationary_ms   <= STATIONARY_MS_RST;
         cfg_ff.cooldown_ms     <= COOLDOWN_MS_RST;
         cfg_ff.still_tolerance <= STILL_TOL_RST;
         cfg_ff.jump_threshold  <= JUMP_THRESHOLD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WRONG_WAY_MS:   cfg_ff.wrong_way_ms    <= csr_wdata;
            CSR_STATIONARY_MS:  cfg_ff.stationary_ms   <= csr_wdata;
            CSR_COOLDOWN_MS:    cfg_ff.cooldown_ms     <= csr_wdata;
            CSR_STILL_TOL:      cfg_ff.still_tolerance <= csr_wdata[TOL_BITS-1:0];
            CSR_JUMP_THRESHOLD: cfg_ff.jump_threshold  <= csr_wdata[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   rht_update u_update (
      .req       (req_ff),
      .entry_vld (vld_ff[req_ff.rider_slot]),
      .entry     (rd_data_ff),
      .cfg       (cfg_ff),
      .entry_new (entry_new),
      .rsp       (rsp_new)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mem_we) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rsp_data_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CALC)
      else $error("accepted beat did not enter the update cycle");

   a_write_needs_room: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CALC) && out_free)
      else $error("table write without a free response register");

   a_held_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.hazard_held == (rsp_data_ff.hazard_kind != KIND_NONE))
      else $error("hazard kind and confirmation disagree");

   a_first_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.first_seen |->
         rsp_data_ff.crash_total == '0 && !rsp_data_ff.hazard_held)
      else $error("new entry not seeded clean");

endmodule

`default_nettype wire
